FILE: hw/rtl/sos_pkg.sv
// Shared types and constants of the scan object segmenter.
`default_nettype none

package sos_pkg;

  // Field widths
  localparam int DIST_W   = 16;
  localparam int STEP_W   = 4;
  localparam int ARC_W    = 16;
  localparam int IDX_W    = 7;
  localparam int RUN_W    = 8;
  localparam int CNT_W    = 3;
  localparam int CENTER_W = 11;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IR_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SONAR_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ARC_PER_SAMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_MIN    = 3'd4;

  // Reset values of the configuration registers
  localparam logic [DIST_W-1:0] RST_IR_LIMIT     = 16'd6400;
  localparam logic [DIST_W-1:0] RST_SONAR_LIMIT  = 16'd3200;
  localparam logic [STEP_W-1:0] RST_ANGLE_STEP   = 4'd2;
  localparam logic [ARC_W-1:0]  RST_ARC_PER_SAMP = 16'd2286;
  localparam logic [DIST_W-1:0] RST_START_MIN    = 16'd6400;

  // Commands from controller to datapath
  typedef struct packed {
    logic step;    // apply one accepted sample
    logic mul;     // second partial product of the width
    logic fin;     // close the object and update the best one
    logic report;  // load the result register and clear the sweep
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic close;     // current sample closes an open object
    logic out_busy;  // result register holds a request not yet taken
  } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scan_object_segmenter.sv
// Top level of the scan object segmenter: sweep samples in, smallest-object report out.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------------
//  in      | in  | in_tvalid / in_tready  | in_tdata 32b, in_tlast ends the sweep
//  out     | out | out_tvalid / out_tready| out_tdata 48b, one request per sweep
//  cfg     | in  | cfg_we                 | cfg_index 3b, cfg_data 16b
//
// A sample that does not close an object is handled in ST_IDLE, a closing sample also
// passes ST_MUL and ST_FIN: the object width is formed as two registered partial products,
// p1_r and prod_r. A last sample then loads the result register in ST_REPORT, and waits
// there while an earlier result is still held. Reset (rst_n low, synchronous) clears
// sweep state and loads register defaults. A stalled output holds its request unchanged.
`default_nettype none

module scan_object_segmenter #(
  parameter int MAX_OBJECTS = 6,
  parameter int MAX_SAMPLES = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // fields from bit 0: ir_distance[15:0], sonar_distance[31:16]
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // fields from bit 0: object_count[2:0], smallest_width[18:3],
  // smallest_center[29:19], smallest_distance[45:30], zero fill
  output logic [47:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  sos_pkg::cmd_t cmd;
  sos_pkg::sts_t sts;

  logic [sos_pkg::CNT_W-1:0]    object_count;
  logic [sos_pkg::DIST_W-1:0]   smallest_width;
  logic [sos_pkg::CENTER_W-1:0] smallest_center;
  logic [sos_pkg::DIST_W-1:0]   smallest_distance;

  sos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sos_datapath #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .ir_distance       (in_tdata[15:0]),
    .sonar_distance    (in_tdata[31:16]),
    .cmd               (cmd),
    .sts               (sts),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .object_count      (object_count),
    .smallest_width    (smallest_width),
    .smallest_center   (smallest_center),
    .smallest_distance (smallest_distance)
  );

  // Pack the result fields, lowest first
  assign out_tdata = {2'b00, smallest_distance, smallest_center, smallest_width, object_count};

endmodule

`default_nettype wire

FILE: hw/rtl/sos_ctrl.sv
// Controller state machine of the scan object segmenter.
`default_nettype none

module sos_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tlast,
  output logic               in_tready,
  input  wire sos_pkg::sts_t sts,
  output sos_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN,
    ST_REPORT
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Sequence commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    last_nxt  = last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.step = 1'b1;
          last_nxt = in_tlast;
          if (sts.close) begin
            state_nxt = ST_MUL;
          end else if (in_tlast) begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = last_r ? ST_REPORT : ST_IDLE;
      end
      ST_REPORT: begin
        if (!sts.out_busy) begin
          cmd.report = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sos_datapath.sv
// Datapath of the scan object segmenter: registers, sweep state, width and centre.
`default_nettype none

module sos_datapath #(
  parameter int MAX_OBJECTS = 6,
  parameter int MAX_SAMPLES = 128
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [sos_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sos_pkg::DIST_W-1:0]          cfg_data,
  input  wire logic [sos_pkg::DIST_W-1:0]          ir_distance,
  input  wire logic [sos_pkg::DIST_W-1:0]          sonar_distance,
  input  wire sos_pkg::cmd_t                       cmd,
  output sos_pkg::sts_t                            sts,
  input  wire logic                                out_tready,
  output logic                                     out_tvalid,
  output logic [sos_pkg::CNT_W-1:0]                object_count,
  output logic [sos_pkg::DIST_W-1:0]               smallest_width,
  output logic [sos_pkg::CENTER_W-1:0]             smallest_center,
  output logic [sos_pkg::DIST_W-1:0]               smallest_distance
);

  localparam int DIST_W   = sos_pkg::DIST_W;
  localparam int IDX_W    = sos_pkg::IDX_W;
  localparam int RUN_W    = sos_pkg::RUN_W;
  localparam int CNT_W    = sos_pkg::CNT_W;
  localparam int CENTER_W = sos_pkg::CENTER_W;
  localparam int STEP_W   = sos_pkg::STEP_W;
  localparam int ARC_W    = sos_pkg::ARC_W;
  localparam int P1_W     = RUN_W + ARC_W;
  localparam int PROD_W   = P1_W + DIST_W;
  localparam int BPROD_W  = RUN_W + STEP_W;

  localparam logic [CNT_W-1:0] MAX_OBJ = CNT_W'(MAX_OBJECTS);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // Configuration registers
  logic [DIST_W-1:0] ir_limit_r, sonar_limit_r, start_min_r;
  logic [STEP_W-1:0] angle_step_r;
  logic [ARC_W-1:0]  arc_r;

  // Sweep state
  logic                inside_r;
  logic [IDX_W-1:0]    idx_r;
  logic [RUN_W-1:0]    run_len_r;
  logic [DIST_W-1:0]   run_min_r;
  logic [CNT_W-1:0]    found_r;
  logic [DIST_W-1:0]   best_w_r, best_d_r;
  logic [CENTER_W-1:0] best_c_r;

  // Width and centre pipeline
  logic [P1_W-1:0]     p1_r;
  logic [PROD_W-1:0]   prod_r;
  logic [CENTER_W-1:0] center_r;

  // Result register
  logic                out_valid_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic [DIST_W-1:0]   out_w_r, out_d_r;
  logic [CENTER_W-1:0] out_c_r;

  logic                active, pass, opening;
  logic [DIST_W-1:0]   open_min;
  logic [CENTER_W-1:0] ang_a;
  logic [BPROD_W-1:0]  ang_bprod;
  logic [CENTER_W-1:0] ang_b;
  logic [CENTER_W-1:0] center_nxt;
  logic [PROD_W-DIST_W-1:0] w_full;
  logic [DIST_W-1:0]   width;
  logic [IDX_W-1:0]    idx_inc;

  assign active  = (found_r < MAX_OBJ);
  assign pass    = (ir_distance < ir_limit_r) && (sonar_distance < sonar_limit_r);
  assign opening = !inside_r && pass;
  assign open_min = (sonar_distance < start_min_r) ? sonar_distance : start_min_r;
  assign idx_inc = (idx_r < IDX_MAX) ? idx_r + 1'b1 : idx_r;

  assign sts.close    = active && inside_r && !pass;
  assign sts.out_busy = out_valid_r && !out_tready;

  // Centre angle: closing index times step less half the run's span
  assign ang_a      = {{(CENTER_W-IDX_W){1'b0}}, idx_r} * {{(CENTER_W-STEP_W){1'b0}}, angle_step_r};
  assign ang_bprod  = {{STEP_W{1'b0}}, run_len_r} * {{RUN_W{1'b0}}, angle_step_r};
  assign ang_b      = ang_bprod[BPROD_W-1:1];
  assign center_nxt = (ang_a > ang_b) ? ang_a - ang_b : '0;

  // Saturate the scaled width
  assign w_full = prod_r[PROD_W-1:DIST_W];
  assign width  = (|w_full[PROD_W-DIST_W-1:DIST_W]) ? '1 : w_full[DIST_W-1:0];

  // Write configuration registers; other indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_limit_r    <= sos_pkg::RST_IR_LIMIT;
      sonar_limit_r <= sos_pkg::RST_SONAR_LIMIT;
      angle_step_r  <= sos_pkg::RST_ANGLE_STEP;
      arc_r         <= sos_pkg::RST_ARC_PER_SAMP;
      start_min_r   <= sos_pkg::RST_START_MIN;
    end else if (cfg_we) begin
      case (cfg_index)
        sos_pkg::REG_IR_LIMIT:     ir_limit_r    <= cfg_data;
        sos_pkg::REG_SONAR_LIMIT:  sonar_limit_r <= cfg_data;
        sos_pkg::REG_ANGLE_STEP:   angle_step_r  <= cfg_data[STEP_W-1:0];
        sos_pkg::REG_ARC_PER_SAMP: arc_r         <= cfg_data;
        sos_pkg::REG_START_MIN:    start_min_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Width products and centre, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      p1_r     <= {{ARC_W{1'b0}}, run_len_r} * {{RUN_W{1'b0}}, arc_r};
      center_r <= center_nxt;
    end
    if (cmd.mul) begin
      prod_r <= {{DIST_W{1'b0}}, p1_r} * {{P1_W{1'b0}}, run_min_r};
    end
  end

  // Advance the sweep state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r  <= 1'b0;
      idx_r     <= '0;
      run_len_r <= '0;
      run_min_r <= sos_pkg::RST_START_MIN;
      found_r   <= '0;
      best_w_r  <= '0;
      best_c_r  <= '0;
      best_d_r  <= '0;
    end else if (cmd.report) begin
      inside_r  <= 1'b0;
      idx_r     <= '0;
      run_len_r <= '0;
      run_min_r <= start_min_r;
      found_r   <= '0;
      best_w_r  <= '0;
      best_c_r  <= '0;
      best_d_r  <= '0;
    end else if (cmd.fin) begin
      if (found_r == '0 || width < best_w_r) begin
        best_w_r <= width;
        best_c_r <= center_r;
        best_d_r <= run_min_r;
      end
      found_r  <= found_r + 1'b1;
      inside_r <= 1'b0;
      idx_r    <= idx_inc;
    end else if (cmd.step && active && !sts.close) begin
      if (opening) begin
        inside_r  <= 1'b1;
        run_len_r <= RUN_W'(1);
        run_min_r <= open_min;
      end else if (inside_r) begin
        if (run_len_r != RUN_MAX) begin
          run_len_r <= run_len_r + 1'b1;
        end
        if (sonar_distance < run_min_r) begin
          run_min_r <= sonar_distance;
        end
      end
      idx_r <= idx_inc;
    end
  end

  // Hold the result request until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.report) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_cnt_r <= found_r;
      out_w_r   <= best_w_r;
      out_c_r   <= best_c_r;
      out_d_r   <= best_d_r;
    end
  end

  assign out_tvalid        = out_valid_r;
  assign object_count      = out_cnt_r;
  assign smallest_width    = out_w_r;
  assign smallest_center   = out_c_r;
  assign smallest_distance = out_d_r;

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench of the scan object segmenter: sweep stimulus, report predictor, checker.
`timescale 1ns / 100ps

module tb;

  localparam int DIST_W    = sos_pkg::DIST_W;
  localparam int STEP_W    = sos_pkg::STEP_W;
  localparam int ARC_W     = sos_pkg::ARC_W;
  localparam int IDX_W     = sos_pkg::IDX_W;
  localparam int RUN_W     = sos_pkg::RUN_W;
  localparam int CNT_W     = sos_pkg::CNT_W;
  localparam int CENTER_W  = sos_pkg::CENTER_W;
  localparam int CFG_IDX_W = sos_pkg::CFG_IDX_W;

  localparam int MAX_OBJ  = 6;
  localparam int MAX_SAMP = 128;
  // Cycles to let pass after the last report before the block counts as idle
  localparam int SETTLE_CYCLES = 20;
  // First register index that the block does not implement
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

  typedef struct packed {
    logic [DIST_W-1:0] ir;
    logic [DIST_W-1:0] sonar;
    logic              sweep_end;
  } sample_t;

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic [DIST_W-1:0]   width;
    logic [CENTER_W-1:0] center;
    logic [DIST_W-1:0]   distance;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sample_t sample_q[$];
  report_t report_q[$];
  int      queued_items = 0;
  int      error_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  // Predictor copy of the registers
  logic [DIST_W-1:0] lim_ir, lim_sonar, start_min;
  logic [STEP_W-1:0] angle_step;
  logic [ARC_W-1:0]  arc_step;

  // Predictor copy of the sweep state
  logic                in_object;
  logic [IDX_W-1:0]    sweep_idx;
  logic [RUN_W-1:0]    run_len;
  logic [DIST_W-1:0]   run_min;
  logic [CNT_W-1:0]    found;
  logic [DIST_W-1:0]   best_w;
  logic [CENTER_W-1:0] best_c;
  logic [DIST_W-1:0]   best_d;

  scan_object_segmenter #(
    .MAX_OBJECTS(MAX_OBJ),
    .MAX_SAMPLES(MAX_SAMP)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Start a fresh sweep
  function automatic void clear_sweep();
    in_object = 1'b0;
    sweep_idx = '0;
    run_len   = '0;
    run_min   = start_min;
    found     = '0;
    best_w    = '0;
    best_c    = '0;
    best_d    = '0;
  endfunction

  // Advance the sweep by one sample; queue the report on the last one
  function automatic void segment_sample(logic [DIST_W-1:0] ir, logic [DIST_W-1:0] sonar,
                                         logic sweep_end);
    logic        hit;
    logic [63:0] prod;
    logic [DIST_W-1:0] width;
    int unsigned a, b;
    logic [CENTER_W-1:0] center;
    report_t rep;
    if (found < MAX_OBJ) begin
      hit = (ir < lim_ir) && (sonar < lim_sonar);
      if (!in_object && hit) begin
        in_object = 1'b1;
        run_len   = '0;
        run_min   = start_min;
      end else if (in_object && !hit) begin
        // close the object: width and centre, keep the strictly narrowest
        prod   = (64'(run_len) * 64'(arc_step) * 64'(run_min)) >> 16;
        width  = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
        a      = sweep_idx * angle_step;
        b      = (run_len * angle_step) >> 1;
        center = (a > b) ? CENTER_W'(a - b) : '0;
        if (found == 0 || width < best_w) begin
          best_w = width;
          best_c = center;
          best_d = run_min;
        end
        found     = found + 1'b1;
        in_object = 1'b0;
      end
      if (in_object) begin
        if (run_len != 8'hFF) run_len = run_len + 1'b1;
        if (sonar < run_min) run_min = sonar;
      end
      if (sweep_idx < MAX_SAMP - 1) sweep_idx = sweep_idx + 1'b1;
    end
    if (sweep_end) begin
      rep.count    = found;
      rep.width    = best_w;
      rep.center   = best_c;
      rep.distance = best_d;
      report_q.push_back(rep);
      clear_sweep();
    end
  endfunction

  // Sender: present queued samples, idle at random between requests
  always @(posedge clk) begin : drive_samples
    sample_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        segment_sample(in_tdata[15:0], in_tdata[31:16], in_tlast);
      if (!in_tvalid || in_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = sample_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {nxt.sonar, nxt.ir};
          in_tlast  <= nxt.sweep_end;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random, check each report against the oldest prediction
  always @(posedge clk) begin : check_reports
    report_t exp_rep;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          $error("report with no prediction pending: %h", out_tdata);
          error_count++;
        end else begin
          exp_rep = report_q.pop_front();
          if (out_tdata[2:0] !== exp_rep.count) begin
            $error("object_count: expected %0d, actual %0d", exp_rep.count, out_tdata[2:0]);
            error_count++;
          end
          if (out_tdata[18:3] !== exp_rep.width) begin
            $error("smallest_width: expected %0d, actual %0d", exp_rep.width, out_tdata[18:3]);
            error_count++;
          end
          if (out_tdata[29:19] !== exp_rep.center) begin
            $error("smallest_center: expected %0d, actual %0d", exp_rep.center,
                   out_tdata[29:19]);
            error_count++;
          end
          if (out_tdata[45:30] !== exp_rep.distance) begin
            $error("smallest_distance: expected %0d, actual %0d", exp_rep.distance,
                   out_tdata[45:30]);
            error_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void queue_sample(logic [DIST_W-1:0] ir, logic [DIST_W-1:0] sonar,
                                       logic sweep_end);
    sample_t s;
    s.ir        = ir;
    s.sonar     = sonar;
    s.sweep_end = sweep_end;
    sample_q.push_back(s);
    queued_items++;
  endfunction

  // A sample that fails at least one limit
  function automatic void queue_miss(logic sweep_end);
    logic [DIST_W-1:0] ir, sonar;
    ir    = 16'($urandom_range(16'hFFFF));
    sonar = 16'($urandom_range(16'hFFFF));
    case ($urandom_range(2))
      0: ir = ($urandom_range(3) == 0) ? lim_ir : 16'($urandom_range(16'hFFFF, lim_ir));
      1: sonar = ($urandom_range(3) == 0) ? lim_sonar :
                 16'($urandom_range(16'hFFFF, lim_sonar));
      default: begin
        ir    = 16'($urandom_range(16'hFFFF, lim_ir));
        sonar = 16'($urandom_range(16'hFFFF, lim_sonar));
      end
    endcase
    queue_sample(ir, sonar, sweep_end);
  endfunction

  // A sample inside both limits, edges favoured; falls back to a miss if none exists
  function automatic void queue_hit(logic sweep_end);
    logic [DIST_W-1:0] ir, sonar;
    if (lim_ir == 0 || lim_sonar == 0) begin
      queue_miss(sweep_end);
    end else begin
      ir    = ($urandom_range(7) == 0) ? lim_ir - 1'b1 : 16'($urandom_range(lim_ir - 1'b1));
      sonar = ($urandom_range(7) == 0) ? lim_sonar - 1'b1 :
              16'($urandom_range(lim_sonar - 1'b1));
      queue_sample(ir, sonar, sweep_end);
    end
  endfunction

  // One sweep: alternating hit and miss runs, a long object, or plain noise
  function automatic void queue_sweep(bit long_run);
    int  n, kind, seg;
    bit  hit_seg;
    kind = $urandom_range(99);
    if (long_run || kind < 2) begin
      // long object that saturates the run length and the sample index
      seg = $urandom_range(20, 1);
      for (int i = 0; i < seg; i++) queue_miss(1'b0);
      n = $urandom_range(290, 258);
      for (int i = 0; i < n; i++) queue_hit(1'b0);
      queue_miss(1'($urandom_range(1)));
      if (!sample_q[$].sweep_end) queue_miss(1'b1);
    end else begin
      n       = $urandom_range(40, 1);
      hit_seg = 1'($urandom_range(1));
      seg     = 0;
      for (int i = 0; i < n; i++) begin
        if (seg == 0) begin
          hit_seg = !hit_seg;
          seg     = $urandom_range(6, 1);
        end
        seg--;
        if (kind >= 90)
          queue_sample(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                       i == n - 1);
        else if (hit_seg)
          queue_hit(i == n - 1);
        else
          queue_miss(i == n - 1);
      end
    end
  endfunction

  // Hold until every sample is taken and every report has come, then let the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_tvalid || report_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      sos_pkg::REG_IR_LIMIT:     lim_ir     = val;
      sos_pkg::REG_SONAR_LIMIT:  lim_sonar  = val;
      sos_pkg::REG_ANGLE_STEP:   angle_step = val[STEP_W-1:0];
      sos_pkg::REG_ARC_PER_SAMP: arc_step   = val;
      sos_pkg::REG_START_MIN:    start_min  = val;
      default: ;
    endcase
  endtask

  task automatic write_setting(logic [15:0] ir, logic [15:0] sonar, logic [15:0] step,
                               logic [15:0] arc, logic [15:0] smin);
    cfg_write(sos_pkg::REG_IR_LIMIT, ir);
    cfg_write(sos_pkg::REG_SONAR_LIMIT, sonar);
    cfg_write(sos_pkg::REG_ANGLE_STEP, step);
    cfg_write(sos_pkg::REG_ARC_PER_SAMP, arc);
    cfg_write(sos_pkg::REG_START_MIN, smin);
    // unimplemented index: must leave every register alone
    cfg_write(REG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(2)), 16'($urandom_range(16'hFFFF)));
    @(posedge clk);
    cfg_we <= 1'b0;
    run_min = start_min;
  endtask

  initial begin
    int target;
    lim_ir     = sos_pkg::RST_IR_LIMIT;
    lim_sonar  = sos_pkg::RST_SONAR_LIMIT;
    angle_step = sos_pkg::RST_ANGLE_STEP;
    arc_step   = sos_pkg::RST_ARC_PER_SAMP;
    start_min  = sos_pkg::RST_START_MIN;
    clear_sweep();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: open at the first sample, closing sample cannot reopen,
    // limit edges, object open at the last sample dropped
    queue_sample(16'd0, 16'd0, 1'b0);
    queue_sample(16'd0, 16'hFFFF, 1'b0);
    queue_sample(16'd6399, 16'd3199, 1'b0);
    queue_sample(16'd6400, 16'd0, 1'b0);
    queue_sample(16'd0, 16'd3200, 1'b0);
    queue_sample(16'd0, 16'd0, 1'b1);
    // sweep of one sample and no object: zero report
    queue_sample(16'hFFFF, 16'hFFFF, 1'b1);
    // the last sample itself closes an object
    queue_sample(16'd100, 16'd100, 1'b0);
    queue_sample(16'd100, 16'd50, 1'b0);
    queue_sample(16'hFFFF, 16'd0, 1'b1);
    // object limit: samples after the sixth object are ignored
    for (int i = 0; i < MAX_OBJ; i++) begin
      queue_sample(16'(10 * (i + 1)), 16'(3000 - 100 * i), 1'b0);
      queue_sample(16'd0, 16'hFFFF, 1'b0);
    end
    queue_sample(16'd0, 16'd1, 1'b1);

    // Random phases over several register settings and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      case (ph)
        0: write_setting(16'd6400, 16'd3200, 16'd2, 16'd2286, 16'd6400);
        1: write_setting(16'hFFFF, 16'hFFFF, 16'd15, 16'hFFFF, 16'hFFFF);
        2: write_setting(16'd0, 16'd3200, 16'd1, 16'd2286, 16'd6400);
        3: write_setting(16'd40000, 16'd20000, 16'd0, 16'd1000, 16'd0);
        4: write_setting(16'd30000, 16'd30000, 16'd7, 16'd0, 16'hFFFF);
        5: write_setting(16'd6400, 16'd3200, 16'd1, 16'd40000, 16'd2000);
        6: write_setting(16'd1, 16'd1, 16'd15, 16'hFFFF, 16'd100);
        default: write_setting(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                               16'($urandom_range(15)), 16'($urandom_range(16'hFFFF)),
                               16'($urandom_range(16'hFFFF)));
      endcase
      if (ph == 1 || ph == 5) queue_sweep(1'b1);
      target = queued_items + 120;
      while (queued_items < target) queue_sweep(1'b0);
    end

    wait_idle();
    if (error_count == 0 && report_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: scan_object_segmenter.f
hw/rtl/sos_pkg.sv
hw/rtl/sos_ctrl.sv
hw/rtl/sos_datapath.sv
hw/rtl/scan_object_segmenter.sv
verif/tb.sv
